[src/tlfo_pkg.sv]
package tlfo_pkg;

  // Default audio sample width.
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed widths of the configuration fields and the LFO state.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int LFO_W = 17;

  // Q1.15 unity.
  localparam logic [CFG_DATA_W:0] ONE_Q15 = 17'd32768;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUARTER_PERIOD = CFG_IDX_W'(1);

  // The LFO ratio c/L is formed one quotient bit per cycle: one integer
  // bit and fifteen fraction bits.
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a sample, step the LFO
    logic div_step;  // one restoring-division step
    logic div_first; // first step: integer quotient bit, no shift
    logic gain_en;   // form the Q2.30 gain
    logic prod_en;   // sample times gain
    logic out_load;  // round, saturate and load the output register
  } tlfo_cmd_t;

endpackage

[src/tlfo_ctrl.sv]
module tlfo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tlfo_pkg::tlfo_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_GAIN = 5'b00100,
    S_PROD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [tlfo_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;
  logic                             div_last;

  assign out_free = !out_valid_r || !out_stall;
  assign div_last = (cnt_r == tlfo_pkg::DIV_CNT_W'(tlfo_pkg::DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: state_nxt = S_PROD;
      S_PROD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.div_step  = (state_r == S_DIV);
    cmd.div_first = (cnt_r == '0);
    cmd.gain_en   = (state_r == S_GAIN);
    cmd.prod_en   = (state_r == S_PROD);
    cmd.out_load  = (state_r == S_OUT) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/tlfo_dpath.sv]
module tlfo_dpath #(
  parameter int SAMPLE_BITS = tlfo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlfo_pkg::tlfo_cmd_t                 cmd,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  input  logic                                cfg_we,
  input  logic [tlfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlfo_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW = tlfo_pkg::CFG_DATA_W;
  localparam int LW = tlfo_pkg::LFO_W;
  localparam int PW = SAMPLE_BITS + 32;
  localparam int QW = SAMPLE_BITS + 2;
  localparam logic signed [QW-1:0] SMAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] SMIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration and LFO state.
  logic [DW-1:0]              mix_r, mix_nxt;
  logic [DW-1:0]              period_r, period_nxt;
  logic signed [LW-1:0]       lfo_r, lfo_nxt;
  logic                       down_r, down_nxt;

  // Per-sample working registers.
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          neg_r;
  logic [LW-1:0]                 rem_r;
  logic [DW-1:0]                 quo_r;
  logic signed [31:0]            gain_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;

  logic signed [LW:0]   lfo_ext, lim_ext, new_lim_ext;
  logic [DW-1:0]        new_lim;
  logic [LW-1:0]        lfo_abs;
  logic [LW:0]          trial;
  logic                 trial_ge;
  logic signed [LW-1:0] ratio;
  logic [LW-1:0]        inv_mix;
  logic signed [33:0]   mix_prod;
  logic signed [33:0]   gain_sum;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] prod_biased;
  logic signed [QW-1:0] quot;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign lfo_ext     = {lfo_r[LW-1], lfo_r};
  assign lim_ext     = $signed({2'b00, period_r});
  assign new_lim     = (cfg_data == '0) ? DW'(1) : cfg_data;
  assign new_lim_ext = $signed({2'b00, new_lim});
  assign lfo_abs     = lfo_r[LW-1] ? LW'(-lfo_r) : LW'(lfo_r);

  // Configuration writes and the LFO step taken when a sample is captured; a write wins over the step.
  always_comb begin
    mix_nxt    = mix_r;
    period_nxt = period_r;
    lfo_nxt    = lfo_r;
    down_nxt   = down_r;
    if (cfg_we) begin
      case (cfg_index)
        tlfo_pkg::REG_MIX_LEVEL: begin
          mix_nxt = ({1'b0, cfg_data} > tlfo_pkg::ONE_Q15) ? DW'(tlfo_pkg::ONE_Q15) : cfg_data;
        end
        tlfo_pkg::REG_QUARTER_PERIOD: begin
          period_nxt = new_lim;
          if (lfo_ext > new_lim_ext) begin
            lfo_nxt = LW'(new_lim_ext);
          end else if (lfo_ext < -new_lim_ext) begin
            lfo_nxt = LW'(-new_lim_ext);
          end
        end
        default: ;
      endcase
    end else if (cmd.load) begin
      if (lfo_ext >= lim_ext) begin
        down_nxt = 1'b1;
      end else if (lfo_ext <= -lim_ext) begin
        down_nxt = 1'b0;
      end
      lfo_nxt = down_nxt ? lfo_r - LW'(1) : lfo_r + LW'(1);
    end
  end

  // Restoring division of |c| * 2^15 by L, one quotient bit per step.
  always_comb begin
    trial    = cmd.div_first ? {1'b0, rem_r} : {rem_r, 1'b0};
    trial_ge = (trial >= {2'b00, period_r});
  end

  // Signed Q1.15 ratio c/L, then the Q2.30 gain.
  assign ratio    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign inv_mix  = tlfo_pkg::ONE_Q15 - {1'b0, mix_r};
  assign mix_prod = $signed({1'b0, mix_r}) * ratio;
  assign gain_sum = $signed({2'b00, inv_mix, 15'd0}) + mix_prod;

  // Divide by 2^30 toward zero, then saturate.
  assign bias        = {{(PW-30){1'b0}}, {30{prod_r[PW-1]}}};
  assign prod_biased = prod_r + bias;
  assign quot        = prod_biased[PW-1:30];
  always_comb begin
    if (quot > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (quot < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r    <= '0;
      period_r <= DW'(1);
      lfo_r    <= '0;
      down_r   <= 1'b0;
    end else begin
      mix_r    <= mix_nxt;
      period_r <= period_nxt;
      lfo_r    <= lfo_nxt;
      down_r   <= down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= sample_in;
      neg_r <= lfo_r[LW-1];
      rem_r <= lfo_abs;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? LW'(trial - {2'b00, period_r}) : trial[LW-1:0];
      quo_r <= {quo_r[DW-2:0], trial_ge};
    end
    if (cmd.gain_en) begin
      gain_r <= gain_sum[31:0];
    end
    if (cmd.prod_en) begin
      prod_r <= x_r * gain_r;
    end
    if (cmd.out_load) begin
      sample_out_r <= sat;
    end
  end

  assign sample_out = sample_out_r;

endmodule

[src/tremolo_triangle_lfo_unit.sv]
// Tremolo with a triangle LFO. Each input transaction carries one signed audio
// sample x; one output transaction returns y = x * ((1 - m) + m * c / L),
// where m is the Q1.15 mix level (32768 is full depth, larger values act as
// full depth), L is the quarter-period count (zero acts as one) and c is an
// LFO counter that traces a triangle between -L and +L, 4*L samples per
// period. c / L is taken to Q1.15 toward zero, the product is divided by
// 2^30 toward zero and saturated to the sample width. After each sample the
// counter turns down at +L, up at -L, and steps by one. Writing the quarter
// period clamps the counter into the new range and keeps its direction.
// Each sample passes through the accept state, the bit-serial divider that
// forms c / L, the gain multiply, the sample multiply and a state that
// rounds, saturates and loads the output register; the next sample is
// accepted only after that. The output register lets a new sample start
// while the previous result waits downstream. Write configuration only
// while the block is idle; cfg_ready is always high.
module tremolo_triangle_lfo_unit #(
  parameter int SAMPLE_BITS = tlfo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Sample input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_in,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  // Configuration write channel: index 0 is the mix level, index 1 the
  // quarter-period count; other indexes are ignored.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlfo_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tlfo_pkg::tlfo_cmd_t cmd;
  logic                cfg_we;

  // Registers are always writable; a write completes in the cycle it is shown.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The controller sequences accept, divide, multiply and output stages.
  tlfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the LFO state and the arithmetic.
  tlfo_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

[tb/sv/tremolo_triangle_lfo_checker.sv]
module tremolo_triangle_lfo_checker #(
  parameter int SAMPLE_BITS = tlfo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [SAMPLE_BITS-1:0]   out_sample_out,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tlfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlfo_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              n_pending,
  output int                              n_fail
);

  localparam longint UNITY = 32768;
  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Mirror of the block's configuration and LFO state.
  logic [16:0]                       depth_q15;
  logic [15:0]                       quarter_len;
  logic signed [tlfo_pkg::LFO_W-1:0] lfo_count;
  logic                              lfo_down;

  logic signed [SAMPLE_BITS-1:0] modulated_q[$];
  logic signed [SAMPLE_BITS-1:0] want;
  int                            fails;

  // Output for one sample at the current LFO position.
  function automatic logic signed [SAMPLE_BITS-1:0] modulate_sample(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    longint lim;
    longint m;
    longint c;
    longint ratio;
    longint gain;
    longint y;
    lim = quarter_len;
    m = depth_q15;
    c = lfo_count;
    ratio = (c * UNITY) / lim;
    gain = (UNITY - m) * UNITY + m * ratio;
    y = (longint'(x) * gain) / (longint'(1) <<< 30);
    if (y > SAT_HI) begin
      y = SAT_HI;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_q15 = '0;
      quarter_len = 16'd1;
      lfo_count = '0;
      lfo_down = 1'b0;
      modulated_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tlfo_pkg::REG_MIX_LEVEL) begin
          depth_q15 = (cfg_data > 16'd32768) ? 17'd32768 : {1'b0, cfg_data};
        end else if (cfg_index == tlfo_pkg::REG_QUARTER_PERIOD) begin
          quarter_len = (cfg_data == '0) ? 16'd1 : cfg_data;
          // The counter is pulled into the new range; direction stays.
          if (lfo_count > $signed({1'b0, quarter_len})) begin
            lfo_count = $signed({1'b0, quarter_len});
          end else if (lfo_count < -$signed({1'b0, quarter_len})) begin
            lfo_count = -$signed({1'b0, quarter_len});
          end
        end
      end

      // Results are retired before new samples are queued.
      if (out_valid && !out_stall) begin
        if (modulated_q.size() == 0) begin
          $error("sample_out: result %0d arrived with no sample pending", out_sample_out);
          fails++;
        end else begin
          want = modulated_q.pop_front();
          if (out_sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_sample_out);
            fails++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        modulated_q.push_back(modulate_sample(in_sample_in));
        if (lfo_count >= $signed({1'b0, quarter_len})) begin
          lfo_down = 1'b1;
        end else if (lfo_count <= -$signed({1'b0, quarter_len})) begin
          lfo_down = 1'b0;
        end
        lfo_count = lfo_down ? lfo_count - 17'sd1 : lfo_count + 17'sd1;
      end
    end
    n_pending <= modulated_q.size();
    n_fail <= fails;
  end

endmodule

[tb/sv/tb_tremolo_triangle_lfo_unit.sv]
module tb_tremolo_triangle_lfo_unit;

  localparam int SAMPLE_BITS = 24;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 100;
  // This margin covers one sample inside the block plus the output register
  // when we wait for the block to settle.
  localparam int SETTLE_CYCLES = 48;
  // Length of the one long receiver hold-off that fills the block.
  localparam int LONG_HOLD_CYCLES = 300;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic signed [SAMPLE_BITS-1:0]         in_sample_in = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0]         out_sample_out;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [tlfo_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [tlfo_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  int n_pending;
  int n_fail;

  // When calm is set neither side idles; used for the last phase of the run.
  bit calm = 1'b0;
  // Raised by the stimulus process to request the long hold-off; the
  // receiver process clears it once the hold-off has been served.
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  tremolo_triangle_lfo_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tremolo_triangle_lfo_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .n_pending     (n_pending),
    .n_fail        (n_fail)
  );

  // Writes one configuration register. The task is entered right after a
  // rising edge and leaves at the edge after the transaction, with valid low,
  // so back-to-back writes never drive valid twice in one time step.
  task automatic write_reg(input logic [tlfo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tlfo_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one sample and returns at the edge where the transaction is
  // taken. Valid is left high so the next sample can follow without a
  // bubble; a random gap is inserted in front of the sample instead.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every queued result has come back, then
  // gives the block a few more cycles so that configuration is written
  // while it is truly idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random samples lean on the rails and on values near zero, where
  // truncation toward zero matters most; the rest are uniform over all bits.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = S_MIN;
      1: v = S_MAX;
      2: begin
        v = SAMPLE_BITS'(int'($urandom_range(0, 32)) - 16);
      end
      default: v = SAMPLE_BITS'($urandom());
    endcase
    return v;
  endfunction

  // Receiver side: short random stall bursts, plus the single long
  // hold-off on request while the sender keeps offering samples, so the
  // block fills up and has to stall its input.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  initial begin
    int mix_val;
    int per_val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: depth above full depth and a zero period both saturate to
    // their limits, and an unknown register index must be ignored. With a
    // period of one the LFO visits -1 every fourth sample, so the most
    // negative sample meets full negative gain and has to saturate to the
    // largest positive value.
    write_reg(tlfo_pkg::REG_MIX_LEVEL, 16'hFFFF);
    write_reg(tlfo_pkg::REG_QUARTER_PERIOD, 16'h0000);
    write_reg(4'hF, 16'($urandom()));
    repeat (4) send_sample(S_MIN);
    repeat (4) send_sample(S_MAX);
    drain();

    // Directed: a longer period lets the counter climb well above the
    // next period, so the following period write has to clamp it while
    // the counting direction is kept.
    write_reg(tlfo_pkg::REG_MIX_LEVEL, 16'd16384);
    write_reg(tlfo_pkg::REG_QUARTER_PERIOD, 16'd10);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sd0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(24'sd12345);
    send_sample(-24'sd12345);
    send_sample(S_MAX);
    drain();
    write_reg(tlfo_pkg::REG_QUARTER_PERIOD, 16'd3);
    repeat (8) send_sample(pick_sample());
    drain();

    // Random phases. The first three fix settings at and next to the extremes
    // of both registers; the rest draw random settings with mostly short periods
    // so the triangle turns many times, and now and then a full 16-bit value.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          mix_val = 0;
          per_val = 16'hFFFF;
        end
        1: begin
          mix_val = 32768;
          per_val = 1;
        end
        2: begin
          mix_val = 32767;
          per_val = 2;
        end
        default: begin
          mix_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 32768);
          per_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 40);
        end
      endcase
      write_reg(tlfo_pkg::REG_QUARTER_PERIOD, 16'(per_val));
      write_reg(tlfo_pkg::REG_MIX_LEVEL, 16'(mix_val));
      write_reg(4'($urandom_range(2, 15)), 16'($urandom()));

      // The last phase runs with no idling on either side.
      if (p == RANDOM_PHASES - 1) begin
        calm = 1'b1;
      end
      // One phase runs under the long receiver hold-off.
      if (p == 2) begin
        hold_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
      drain();
    end

    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS tremolo_triangle_lfo_unit");
    end else begin
      $display("FAIL tremolo_triangle_lfo_unit");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("FAIL tremolo_triangle_lfo_unit");
    $finish;
  end

endmodule

[files.f]
src/tlfo_pkg.sv
src/tlfo_ctrl.sv
src/tlfo_dpath.sv
src/tremolo_triangle_lfo_unit.sv
tb/sv/tremolo_triangle_lfo_checker.sv
tb/sv/tb_tremolo_triangle_lfo_unit.sv
